### rtl/aesinv_pkg.sv
// Package for the AES inverse cipher unit: S-box tables, Rcon, GF(2^8) helpers,
// register indexes and control types. Used by every module under rtl.
// No dependencies.
package aesinv_pkg;

	localparam int KsWords = 60;
	localparam int KsAddrW = 6;

	localparam logic [2:0] REG_KEY_SIZE = 3'd0;
	localparam logic [2:0] REG_KEY_W0   = 3'd1;
	localparam logic [2:0] REG_KEY_W1   = 3'd2;
	localparam logic [2:0] REG_KEY_W2   = 3'd3;
	localparam logic [2:0] REG_KEY_W3   = 3'd4;

	typedef logic [7:0] byte_t;
	typedef logic [127:0] block_t;

	typedef struct packed {
		logic       start;
		logic [3:0] nk;
		logic [3:0] nr;
	} ks_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ks_sts_t;

	localparam byte_t FWD_SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam byte_t INV_SBOX [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	localparam byte_t RCON [10] = '{
		8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
	};

	function automatic byte_t xtime(input byte_t a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
	endfunction

	// 9,11,13,14 multiples built from x2/x4/x8
	function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
		byte_t a [4];
		byte_t m2 [4];
		byte_t m4 [4];
		byte_t m8 [4];
		byte_t m9 [4];
		byte_t mb [4];
		byte_t md [4];
		byte_t me [4];
		for (int i = 0; i < 4; i++) begin
			a[i]  = c[31-8*i -: 8];
			m2[i] = xtime(a[i]);
			m4[i] = xtime(m2[i]);
			m8[i] = xtime(m4[i]);
			m9[i] = m8[i] ^ a[i];
			mb[i] = m8[i] ^ m2[i] ^ a[i];
			md[i] = m8[i] ^ m4[i] ^ a[i];
			me[i] = m8[i] ^ m4[i] ^ m2[i];
		end
		return {me[0] ^ mb[1] ^ md[2] ^ m9[3],
		        m9[0] ^ me[1] ^ mb[2] ^ md[3],
		        md[0] ^ m9[1] ^ me[2] ^ mb[3],
		        mb[0] ^ md[1] ^ m9[2] ^ me[3]};
	endfunction

	function automatic block_t inv_shift_sub(input block_t s);
		block_t t;
		for (int r = 0; r < 4; r++) begin
			for (int c = 0; c < 4; c++) begin
				t[127-8*(4*((c+r)%4)+r) -: 8] = INV_SBOX[s[127-8*(4*c+r) -: 8]];
			end
		end
		return t;
	endfunction

	function automatic block_t inv_mix(input block_t s);
		block_t t;
		for (int c = 0; c < 4; c++) begin
			t[127-32*c -: 32] = inv_mix_col(s[127-32*c -: 32]);
		end
		return t;
	endfunction

endpackage

### rtl/aes_inverse_cipher_unit.sv
// AES inverse cipher top level: config registers, round sequencer, output word.
// Depends on aesinv_pkg and aesinv_keysched.
//
//  channel | signals                              | direction
//  cfg     | cfg_we, cfg_index, cfg_data          | in
//  in      | in_valid, in_stall, cipher_high/low  | in (stall out)
//  out     | out_valid, out_stall, plain_high/low | out (stall in)
//
// From accept to next accept a word passes a round-key read, one round per cycle
// through the shared round unit, and the return to idle. After a key change the
// first word first waits for the schedule expander.
// Reset clears control; key registers clear to zero. A stalled result holds in
// the output register; the next word is accepted meanwhile, and its last round
// waits until that register frees.
module aes_inverse_cipher_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [63:0] cipher_high,
	input  logic [63:0] cipher_low,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [63:0] plain_high,
	output logic [63:0] plain_low
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_KEYS  = 3'd1;
	localparam logic [2:0] ST_FETCH = 3'd2;
	localparam logic [2:0] ST_ROUND = 3'd3;
	localparam logic [2:0] ST_LAST  = 3'd4;

	logic [1:0]   ksize_q;
	logic [255:0] key_q;
	logic         ready_q;
	logic [2:0]   st_q;
	logic [3:0]   rnd_q;
	logic [127:0] blk_q;
	logic         ov_q;
	logic [127:0] res_q;
	logic [3:0]   nr;
	logic [3:0]   nk;
	logic [3:0]   rd_round;
	logic [127:0] rd_key;
	logic [127:0] ss;
	logic         acc;
	logic         last_go;
	aesinv_pkg::ks_ctl_t ks_ctl;
	aesinv_pkg::ks_sts_t ks_sts;

	always_comb begin
		unique case (ksize_q)
			2'd0: begin nr = 4'd10; nk = 4'd4; end
			2'd1: begin nr = 4'd12; nk = 4'd6; end
			default: begin nr = 4'd14; nk = 4'd8; end
		endcase
	end

	assign in_stall = (st_q != ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign last_go  = (st_q == ST_LAST) && (!ov_q || !out_stall);
	assign ks_ctl   = '{start: acc && !ready_q, nk: nk, nr: nr};
	// key read is registered: fetch the key of the round that runs next cycle
	assign rd_round = (st_q == ST_IDLE || st_q == ST_KEYS) ? nr
	                  : (st_q == ST_LAST) ? 4'd0 : rnd_q - 4'd1;
	assign ss       = aesinv_pkg::inv_shift_sub(blk_q) ^ rd_key;

	aesinv_keysched u_ks (
		.clk(clk), .arst_n(arst_n), .ctl(ks_ctl), .key(key_q),
		.rd_round(rd_round), .rd_key(rd_key), .sts(ks_sts)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ksize_q <= '0;
			key_q   <= '0;
			ready_q <= 1'b0;
			st_q    <= ST_IDLE;
			ov_q    <= 1'b0;
			rnd_q   <= '0;
		end else begin
			if (cfg_we && cfg_index <= aesinv_pkg::REG_KEY_W3) begin
				ready_q <= 1'b0;
				unique case (cfg_index)
					aesinv_pkg::REG_KEY_SIZE: ksize_q <= (cfg_data[1:0] == 2'd3) ? 2'd2
					                                     : cfg_data[1:0];
					aesinv_pkg::REG_KEY_W0: key_q[255:192] <= cfg_data;
					aesinv_pkg::REG_KEY_W1: key_q[191:128] <= cfg_data;
					aesinv_pkg::REG_KEY_W2: key_q[127:64]  <= cfg_data;
					aesinv_pkg::REG_KEY_W3: key_q[63:0]    <= cfg_data;
					default: ;
				endcase
			end
			if (out_valid && !out_stall) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: if (acc) begin
					st_q  <= ready_q ? ST_FETCH : ST_KEYS;
					rnd_q <= nr;
				end
				ST_KEYS: if (ks_sts.done) begin
					ready_q <= 1'b1;
					st_q    <= ST_FETCH;
				end
				ST_FETCH: begin
					rnd_q <= rnd_q - 4'd1;
					st_q  <= ST_ROUND;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q - 4'd1;
					if (rnd_q == 4'd1) begin
						st_q <= ST_LAST;
					end
				end
				ST_LAST: if (last_go) begin
					ov_q <= 1'b1;
					st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			blk_q <= {cipher_high, cipher_low};
		end else if (st_q == ST_FETCH) begin
			blk_q <= blk_q ^ rd_key;
		end else if (st_q == ST_ROUND) begin
			blk_q <= aesinv_pkg::inv_mix(ss);
		end
		if (last_go) begin
			res_q <= ss;
		end
	end

	assign out_valid  = ov_q;
	assign plain_high = res_q[127:64];
	assign plain_low  = res_q[63:0];

`ifndef SYNTHESIS
	a_no_acc_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != ST_IDLE) |-> !acc) else $error("word accepted while busy");
	a_out_from_last: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(ov_q) |-> $past(st_q) == ST_LAST) else $error("result without last round");
	a_keys_wait: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_FETCH) |-> ready_q) else $error("rounds start without schedule");
`endif
endmodule

### rtl/aesinv_keysched.sv
// Key schedule expander: one schedule word per cycle into the round-key store.
// Also serves the round-key reads of the datapath. Depends on aesinv_pkg.
module aesinv_keysched (
	input  logic                        clk,
	input  logic                        arst_n,
	input  aesinv_pkg::ks_ctl_t         ctl,
	input  logic [255:0]                key,
	input  logic [aesinv_pkg::KsAddrW-3:0] rd_round,
	output logic [127:0]                rd_key,
	output aesinv_pkg::ks_sts_t         sts
);
	// stored as four column banks, one word a cycle written, one row read
	logic [31:0] bank0 [15];
	logic [31:0] bank1 [15];
	logic [31:0] bank2 [15];
	logic [31:0] bank3 [15];
	// last 8 words in a shift line for w[i-1] and w[i-nk]
	logic [31:0] win_q [8];
	logic [5:0]  idx_q;
	logic [5:0]  total_q;
	logic [3:0]  nk_q;
	logic [3:0]  ph_q;     // i mod nk
	logic [3:0]  rc_q;     // rcon index
	logic        busy_q;
	logic        done_q;
	logic [31:0] t_w;
	logic [31:0] old_w;
	logic [31:0] new_w;
	logic [31:0] key_w;

	always_comb begin
		t_w = win_q[0];
		if (ph_q == 4'd0) begin
			t_w = aesinv_pkg::sub_word({win_q[0][23:0], win_q[0][31:24]})
			      ^ {aesinv_pkg::RCON[rc_q], 24'd0};
		end else if (nk_q == 4'd8 && ph_q == 4'd4) begin
			t_w = aesinv_pkg::sub_word(win_q[0]);
		end
		old_w = win_q[nk_q[2:0] - 3'd1];
		key_w = key[255-32*idx_q[2:0] -: 32];
		new_w = (idx_q < {2'b0, nk_q}) ? key_w : (old_w ^ t_w);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
			ph_q   <= '0;
			rc_q   <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q  <= 1'b1;
				idx_q   <= '0;
				ph_q    <= '0;
				rc_q    <= '0;
				nk_q    <= ctl.nk;
				total_q <= {ctl.nr, 2'b00} + 6'd4;
			end else if (busy_q) begin
				idx_q <= idx_q + 6'd1;
				if (idx_q >= {2'b0, nk_q}) begin
					if (ph_q == nk_q - 4'd1) begin
						ph_q <= '0;
					end else begin
						ph_q <= ph_q + 4'd1;
					end
					if (ph_q == 4'd0) begin
						rc_q <= rc_q + 4'd1;
					end
				end
				if (idx_q == total_q - 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			win_q[0] <= new_w;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k-1];
			end
			unique case (idx_q[1:0])
				2'd0: bank0[idx_q[5:2]] <= new_w;
				2'd1: bank1[idx_q[5:2]] <= new_w;
				2'd2: bank2[idx_q[5:2]] <= new_w;
				default: bank3[idx_q[5:2]] <= new_w;
			endcase
		end
		rd_key <= {bank0[rd_round], bank1[rd_round], bank2[rd_round], bank3[rd_round]};
	end

	assign sts = '{busy: busy_q, done: done_q};

`ifndef SYNTHESIS
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !ctl.start) else $error("schedule restarted while expanding");
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q)) else $error("done without expansion");
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> idx_q < 6'd60) else $error("schedule index overrun");
`endif
endmodule
